FILE: rtl/core/shbc_pkg.sv
`default_nettype none

package shbc_pkg;

  localparam int HASH_W        = 64;
  localparam int BYTE_W        = 8;
  localparam int CHAR_W        = 7;
  localparam int POS_OUT_W     = 3;
  localparam int CODE_DIGITS   = 6;
  localparam int POS_W         = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int RADIX         = 62;
  localparam int REM_W         = 6;
  localparam int BITS_PER_STEP = 8;
  localparam int STEPS         = HASH_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);
  localparam logic [BYTE_W-1:0] TERM_BYTE = '0;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_UPPER = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] ASCII_LOWER = CHAR_W'(97);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } hash_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // base-62 digit to ascii
  function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    logic [CHAR_W-1:0] res;
    dx = CHAR_W'(d);
    if (d < REM_W'(10)) begin
      res = ASCII_ZERO + dx;
    end else if (d < REM_W'(36)) begin
      res = ASCII_UPPER + dx - CHAR_W'(10);
    end else begin
      res = ASCII_LOWER + dx - CHAR_W'(36);
    end
    return res;
  endfunction

  // position counter to the 3-bit output field
  function automatic logic [POS_OUT_W-1:0] pos_out(input logic [POS_W-1:0] p);
    logic [POS_W+POS_OUT_W-1:0] ext;
    ext = {{POS_OUT_W{1'b0}}, p};
    return ext[POS_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shbc_front.sv
`default_nettype none

module shbc_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [shbc_pkg::BYTE_W-1:0]      char_byte_i,
  input  shbc_pkg::queue_stat_t            qstat_i,
  output shbc_pkg::hash_push_t             push_o
);

  logic [shbc_pkg::HASH_W-1:0] hash_q, hash_d;
  logic                        is_term;
  logic                        accept;

  assign is_term    = (char_byte_i == shbc_pkg::TERM_BYTE);
  // plain bytes never wait on the back end
  assign in_ready_o = !is_term || !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign push_o.valid = accept && is_term;
  assign push_o.hash  = hash_q;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      if (is_term) begin
        hash_d = shbc_pkg::HASH_SEED;
      end else begin
        hash_d = (hash_q << 5) + hash_q + shbc_pkg::HASH_W'(char_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= shbc_pkg::HASH_SEED;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/shbc_queue.sv
`default_nettype none

module shbc_queue (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  shbc_pkg::hash_push_t         push_i,
  input  wire                          pop_i,
  output logic [shbc_pkg::HASH_W-1:0]  head_o,
  output shbc_pkg::queue_stat_t        stat_o
);

  logic [shbc_pkg::HASH_W-1:0] mem_q [shbc_pkg::QDEPTH];
  logic [shbc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [shbc_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign stat_o.full  = (cnt_q == shbc_pkg::QCNT_W'(shbc_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !stat_o.full)
    else $error("push into full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= shbc_pkg::QCNT_W'(shbc_pkg::QDEPTH))
    else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

FILE: rtl/core/shbc_back.sv
`default_nettype none

module shbc_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  shbc_pkg::queue_stat_t           qstat_i,
  input  wire  [shbc_pkg::HASH_W-1:0]     head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [shbc_pkg::CHAR_W-1:0]     code_char_o,
  output logic [shbc_pkg::POS_OUT_W-1:0]  digit_position_o,
  output logic                            code_empty_o,
  output logic                            last_of_code_o
);

  shbc_pkg::back_state_e state_q, state_d;

  logic [shbc_pkg::HASH_W-1:0]        quo_q, quo_d;
  logic [shbc_pkg::REM_W-1:0]         rem_q, rem_d;
  logic [shbc_pkg::STEP_W-1:0]        step_q, step_d;
  logic [shbc_pkg::POS_W-1:0]         pos_q, pos_d;
  logic                               empty_q, empty_d;

  logic                               out_valid_q;
  logic [shbc_pkg::CHAR_W-1:0]        char_q;
  logic [shbc_pkg::POS_OUT_W-1:0]     opos_q;
  logic                               oempty_q, olast_q;

  logic                               slot_free;
  logic                               is_last;
  logic                               emit;
  logic [shbc_pkg::REM_W-1:0]         div_rem;
  logic [shbc_pkg::BITS_PER_STEP-1:0] div_qbits;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_last   = empty_q || (quo_q == '0) ||
                     (pos_q == shbc_pkg::POS_W'(shbc_pkg::CODE_DIGITS - 1));
  assign emit      = (state_q == shbc_pkg::ST_EMIT) && slot_free;
  assign pop_o     = (state_q == shbc_pkg::ST_IDLE) && !qstat_i.empty;

  // restoring division by 62 on the top byte of the dividend
  always_comb begin
    logic [shbc_pkg::REM_W:0] r;
    r = {1'b0, rem_q};
    div_qbits = '0;
    for (int i = 0; i < shbc_pkg::BITS_PER_STEP; i++) begin
      r = {r[shbc_pkg::REM_W-1:0], quo_q[shbc_pkg::HASH_W-1-i]};
      if (r >= (shbc_pkg::REM_W+1)'(shbc_pkg::RADIX)) begin
        r = r - (shbc_pkg::REM_W+1)'(shbc_pkg::RADIX);
        div_qbits[shbc_pkg::BITS_PER_STEP-1-i] = 1'b1;
      end
    end
    div_rem = r[shbc_pkg::REM_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    pos_d   = pos_q;
    empty_d = empty_q;
    case (state_q)
      shbc_pkg::ST_IDLE: begin
        if (pop_o) begin
          quo_d   = head_i;
          rem_d   = '0;
          step_d  = '0;
          pos_d   = '0;
          empty_d = (head_i == '0);
          state_d = (head_i == '0) ? shbc_pkg::ST_EMIT : shbc_pkg::ST_DIV;
        end
      end
      shbc_pkg::ST_DIV: begin
        quo_d  = {quo_q[shbc_pkg::HASH_W-shbc_pkg::BITS_PER_STEP-1:0], div_qbits};
        rem_d  = div_rem;
        step_d = step_q + 1'b1;
        if (step_q == shbc_pkg::STEP_W'(shbc_pkg::STEPS - 1)) begin
          state_d = shbc_pkg::ST_EMIT;
        end
      end
      shbc_pkg::ST_EMIT: begin
        if (slot_free) begin
          if (is_last) begin
            state_d = shbc_pkg::ST_IDLE;
          end else begin
            rem_d   = '0;
            step_d  = '0;
            pos_d   = pos_q + 1'b1;
            state_d = shbc_pkg::ST_DIV;
          end
        end
      end
      default: begin
        state_d = shbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shbc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    pos_q   <= pos_d;
    empty_q <= empty_d;
    if (emit) begin
      char_q   <= empty_q ? '0 : shbc_pkg::digit_char(rem_q);
      opos_q   <= shbc_pkg::pos_out(pos_q);
      oempty_q <= empty_q;
      olast_q  <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_char_o      = char_q;
  assign digit_position_o = opos_q;
  assign code_empty_o     = oempty_q;
  assign last_of_code_o   = olast_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == shbc_pkg::ST_EMIT) |-> (rem_q < shbc_pkg::REM_W'(shbc_pkg::RADIX)))
    else $error("remainder not below radix");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != shbc_pkg::ST_IDLE) |->
      (pos_q < shbc_pkg::POS_W'(shbc_pkg::CODE_DIGITS - 1) ||
       pos_q == shbc_pkg::POS_W'(shbc_pkg::CODE_DIGITS - 1)))
    else $error("digit position past code length");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == shbc_pkg::ST_EMIT) && empty_q) |-> (quo_q == '0))
    else $error("empty code with nonzero hash");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(char_q))
    else $error("result overwritten while pending");

endmodule

`default_nettype wire

FILE: rtl/core/string_hash_base62_code_core.sv
// latency: a nonzero byte is hashed in the cycle it is accepted, one byte per cycle
// terminator: hash queued, then popped, then a divide pass and an emit per digit
// a code has at most six digits
// throughput set by the 8-bit-per-cycle divider loop; nonzero bytes keep flowing while it runs
// reset: hash back to 5381, code queue empty, no result pending
`default_nettype none

module string_hash_base62_code_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // byte channel
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [shbc_pkg::BYTE_W-1:0]     char_byte_i,
  // code character channel
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [shbc_pkg::CHAR_W-1:0]     code_char_o,
  output logic [shbc_pkg::POS_OUT_W-1:0]  digit_position_o,
  output logic                            code_empty_o,
  output logic                            last_of_code_o
);

  // front: djb2 update per byte, terminator pushes the finished hash
  shbc_pkg::hash_push_t        push;
  // queue status seen by both sides
  shbc_pkg::queue_stat_t       qstat;
  logic [shbc_pkg::HASH_W-1:0] head;
  logic                        pop;

  shbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .qstat_i     (qstat),
    .push_o      (push)
  );

  // two-entry hash queue so hashing waits on the digit drain only when the queue is full
  shbc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  // back: serial divide by 62, one output transaction per digit
  shbc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .qstat_i          (qstat),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_char_o      (code_char_o),
    .digit_position_o (digit_position_o),
    .code_empty_o     (code_empty_o),
    .last_of_code_o   (last_of_code_o)
  );

endmodule

`default_nettype wire
